>>> sv/uart8_pkg.sv
// Shared types and constants for the 8N1 UART with receive FIFO.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uart8_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SEND  = 2'd1,
    CMD_POP   = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_STOP  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    CFG_RX_CENTER  = 3'd0,
    CFG_RX_BIT     = 3'd1,
    CFG_RX_STOP    = 3'd2,
    CFG_TX_BIT     = 3'd3,
    CFG_TX_EXTRA   = 3'd4,
    CFG_LISTEN     = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CountW   = 6;
  localparam int unsigned TxTimerW = 17;
  localparam logic [7:0]  TxExtraRst = 8'd5;

  typedef struct packed {
    logic [15:0] rx_center_delay;
    logic [15:0] rx_bit_delay;
    logic [15:0] rx_stop_delay;
    logic [15:0] tx_bit_delay;
    logic [7:0]  tx_start_extra;
    logic        listen_enable;
  } cfg_t;

  // decoded tick held in the front queue
  typedef struct packed {
    logic       send;
    logic       pop;
    logic       flush;
    logic       rx_level;
    logic [7:0] send_byte;
  } tick_t;

endpackage

`default_nettype wire

>>> sv/uart8_front.sv
// Front end: accepts ticks, decodes the command and queues them (two entries).
// Depends on uart8_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uart8_front import uart8_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] command_i,
  input  wire logic       rx_level_i,
  input  wire logic [7:0] send_byte_i,
  output logic            tick_valid_o,
  output tick_t           tick_o,
  input  wire logic       tick_take_i
);

  tick_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  tick_t      dec;
  logic       push, take;

  always_comb begin
    dec           = '0;
    dec.rx_level  = rx_level_i;
    dec.send_byte = send_byte_i;
    case (cmd_e'(command_i))
      CMD_TICK:  ;
      CMD_SEND:  dec.send  = 1'b1;
      CMD_POP:   dec.pop   = 1'b1;
      CMD_FLUSH: dec.flush = 1'b1;
      default:   ;
    endcase
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign tick_valid_o = (count_q != 2'd0);
  assign tick_o       = slot_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign take         = tick_take_i && tick_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = take ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= dec;
    end
  end

endmodule

`default_nettype wire

>>> sv/uart8_rx.sv
// Receiver: start detect, centring wait, eight data samples, stop wait.
// Depends on uart8_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uart8_rx import uart8_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  wire logic level_i,
  input  wire cfg_t cfg_i,
  output logic      push_o,
  output logic [7:0] push_data_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] timer_q, timer_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic        enabled, push;

  assign enabled = cfg_i.listen_enable && (cfg_i.rx_stop_delay != 16'd0);

  always_comb begin
    phase_d = phase_q;
    if (!enabled) begin
      phase_d = PH_IDLE;
    end else begin
      case (phase_q)
        PH_IDLE:  if (!level_i) phase_d = PH_START;
        PH_START: if (timer_q == 16'd0) phase_d = PH_DATA;
        PH_DATA:  if (timer_q == 16'd0 && cnt_q == 3'd7) phase_d = PH_STOP;
        PH_STOP:  if (timer_q == 16'd0) phase_d = PH_IDLE;
        default:  phase_d = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    timer_d = timer_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    push    = 1'b0;
    if (!enabled) begin
      timer_d = 16'd0;
      cnt_d   = 3'd0;
    end else if (phase_q == PH_IDLE) begin
      if (!level_i) begin
        timer_d = cfg_i.rx_center_delay;
        cnt_d   = 3'd0;
        shift_d = 8'd0;
      end
    end else if (timer_q != 16'd0) begin
      timer_d = timer_q - 16'd1;
    end else begin
      case (phase_q)
        PH_START: timer_d = cfg_i.rx_bit_delay;
        PH_DATA: begin
          shift_d[cnt_q] = level_i;
          if (cnt_q == 3'd7) begin
            cnt_d   = 3'd0;
            timer_d = cfg_i.rx_stop_delay;
          end else begin
            cnt_d   = cnt_q + 3'd1;
            timer_d = cfg_i.rx_bit_delay;
          end
        end
        PH_STOP: push = 1'b1;
        default: ;
      endcase
    end
  end

  assign push_o      = step_i && push;
  assign push_data_o = shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= 16'd0;
      cnt_q   <= 3'd0;
      shift_q <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/uart8_tx.sv
// Transmitter: long start bit, eight data bits LSB first, one stop bit.
// Depends on uart8_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uart8_tx import uart8_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic       send_i,
  input  wire logic [7:0] send_byte_i,
  input  wire cfg_t       cfg_i,
  output logic            accepted_o,
  output logic            line_o,
  output logic            busy_o
);

  phase_e                phase_q, phase_d, phase_adv;
  logic [TxTimerW-1:0]   timer_q, timer_d, bit_wait;
  logic [2:0]            cnt_q, cnt_d;
  logic [7:0]            shift_q, shift_d;
  logic                  line_q, line_d;
  logic                  start;

  assign bit_wait = (cfg_i.tx_bit_delay == 16'd0) ? '0
                  : TxTimerW'(cfg_i.tx_bit_delay) - TxTimerW'(1);

  always_comb begin
    phase_adv = phase_q;
    if (timer_q == '0) begin
      case (phase_q)
        PH_IDLE:  phase_adv = PH_IDLE;
        PH_START: phase_adv = PH_DATA;
        PH_DATA:  if (cnt_q == 3'd7) phase_adv = PH_STOP;
        PH_STOP:  phase_adv = PH_IDLE;
        default:  phase_adv = PH_IDLE;
      endcase
    end
  end

  assign start = send_i && (phase_adv == PH_IDLE) && (cfg_i.tx_bit_delay != 16'd0);

  always_comb begin
    phase_d = start ? PH_START : phase_adv;
  end

  always_comb begin
    timer_d = timer_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    line_d  = line_q;
    if (phase_q == PH_IDLE) begin
      line_d = 1'b1;
    end else if (timer_q != '0) begin
      timer_d = timer_q - TxTimerW'(1);
    end else begin
      case (phase_q)
        PH_START: begin
          cnt_d   = 3'd0;
          line_d  = shift_q[0];
          timer_d = bit_wait;
        end
        PH_DATA: begin
          if (cnt_q == 3'd7) begin
            line_d = 1'b1;
          end else begin
            cnt_d  = cnt_q + 3'd1;
            line_d = shift_q[cnt_q + 3'd1];
          end
          timer_d = bit_wait;
        end
        PH_STOP: begin
          line_d = 1'b1;
          cnt_d  = 3'd0;
        end
        default: ;
      endcase
    end
    if (start) begin
      shift_d = send_byte_i;
      cnt_d   = 3'd0;
      line_d  = 1'b0;
      timer_d = TxTimerW'(cfg_i.tx_bit_delay) + TxTimerW'(cfg_i.tx_start_extra)
              - TxTimerW'(1);
    end
  end

  assign accepted_o = start;
  assign line_o     = line_q;
  assign busy_o     = (phase_q != PH_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
      cnt_q   <= 3'd0;
      shift_q <= 8'd0;
      line_q  <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      line_q  <= line_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/uart8_rxfifo.sv
// Receive ring buffer: pop, flush, push with sticky overflow; one slot kept free.
// Depends on uart8_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uart8_rxfifo import uart8_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic       listen_i,
  input  wire logic       pop_i,
  input  wire logic       flush_i,
  input  wire logic       push_i,
  input  wire logic [7:0] push_data_i,
  output logic            pop_ok_o,
  output logic [7:0]      rd_data_o,
  output logic [CountW-1:0] count_next_o,
  output logic            overflow_o
);

  localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW = (AW + 1 > CountW) ? AW + 1 : CountW;
  localparam logic [AW-1:0] LastIdx = AW'(FIFO_DEPTH - 1);

  logic [7:0]    mem [FIFO_DEPTH];
  logic [7:0]    rd_q;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [AW-1:0] head1, tail1, tail_nx;
  logic          drop_q, drop_d;
  logic          pop_ok, do_write;
  logic [CW-1:0] fill;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == LastIdx) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    pop_ok   = step_i && listen_i && pop_i && (head_q != tail_q);
    head1    = head_q;
    tail1    = tail_q;
    if (listen_i && pop_i && (head_q != tail_q)) begin
      head1 = ring_next(head_q);
    end else if (listen_i && flush_i) begin
      head1 = '0;
      tail1 = '0;
    end
    tail_nx  = ring_next(tail1);
    do_write = push_i && (tail_nx != head1);
    head_d   = head1;
    tail_d   = do_write ? tail_nx : tail1;
    drop_d   = drop_q || (push_i && (tail_nx == head1));
    if (tail_d >= head_d) begin
      fill = CW'(tail_d) - CW'(head_d);
    end else begin
      fill = CW'(tail_d) + CW'(FIFO_DEPTH) - CW'(head_d);
    end
  end

  assign pop_ok_o     = pop_ok;
  assign rd_data_o    = rd_q;
  assign count_next_o = listen_i ? fill[CountW-1:0] : '0;
  assign overflow_o   = drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      drop_q <= 1'b0;
    end else if (step_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
      drop_q <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && do_write) begin
      mem[tail1] <= push_data_i;
    end
    if (pop_ok) begin
      rd_q <= mem[head_q];
    end
  end

endmodule

`default_nettype wire

>>> sv/uart_8n1_with_rx_fifo.sv
// 8N1 UART transceiver with receive FIFO: each accepted item is one line tick
// and yields exactly one result. A two-entry input queue feeds the tick engine
// (receiver, transmitter, FIFO), which advances one tick per clock whenever the
// result register is free or being taken, so one item per cycle is sustained.
// The FIFO read is registered in the same edge as the tick, so the popped byte
// is valid together with its result. The user must write configuration through
// cfg_we_i/cfg_index_i/cfg_data_i only while idle; the block does not enforce it.
// Depends on uart8_pkg, uart8_front, uart8_rx, uart8_tx, uart8_rxfifo.
`timescale 1ns / 1ps
`default_nettype none

module uart_8n1_with_rx_fifo import uart8_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          command_i,
  input  wire logic                rx_level_i,
  input  wire logic [7:0]          send_byte_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     tx_level_o,
  output logic [7:0]               popped_byte_o,
  output logic                     popped_valid_o,
  output logic [CountW-1:0]        fifo_count_o,
  output logic                     overflow_flag_o,
  output logic                     tx_busy_o,
  output logic                     send_accepted_o
);

  cfg_t              cfg_q;
  tick_t             tick;
  logic              tick_valid, fire;
  logic              out_valid_q;
  logic              popped_valid_q, accepted_q;
  logic [CountW-1:0] count_q;
  logic              pop_ok, push, accepted;
  logic [7:0]        push_data, rd_data;
  logic [CountW-1:0] count_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{rx_center_delay: 16'd0,
                 rx_bit_delay:    16'd0,
                 rx_stop_delay:   16'd0,
                 tx_bit_delay:    16'd0,
                 tx_start_extra:  TxExtraRst,
                 listen_enable:   1'b1};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_RX_CENTER: cfg_q.rx_center_delay <= cfg_data_i;
        CFG_RX_BIT:    cfg_q.rx_bit_delay    <= cfg_data_i;
        CFG_RX_STOP:   cfg_q.rx_stop_delay   <= cfg_data_i;
        CFG_TX_BIT:    cfg_q.tx_bit_delay    <= cfg_data_i;
        CFG_TX_EXTRA:  cfg_q.tx_start_extra  <= cfg_data_i[7:0];
        CFG_LISTEN:    cfg_q.listen_enable   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  uart8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .rx_level_i   (rx_level_i),
    .send_byte_i  (send_byte_i),
    .tick_valid_o (tick_valid),
    .tick_o       (tick),
    .tick_take_i  (fire)
  );

  assign fire = tick_valid && (!out_valid_q || out_ready_i);

  uart8_rxfifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_rxfifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (fire),
    .listen_i     (cfg_q.listen_enable),
    .pop_i        (tick.pop),
    .flush_i      (tick.flush),
    .push_i       (push),
    .push_data_i  (push_data),
    .pop_ok_o     (pop_ok),
    .rd_data_o    (rd_data),
    .count_next_o (count_next),
    .overflow_o   (overflow_flag_o)
  );

  uart8_rx u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (fire),
    .level_i     (tick.rx_level),
    .cfg_i       (cfg_q),
    .push_o      (push),
    .push_data_o (push_data)
  );

  uart8_tx u_tx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (fire),
    .send_i      (tick.send),
    .send_byte_i (tick.send_byte),
    .cfg_i       (cfg_q),
    .accepted_o  (accepted),
    .line_o      (tx_level_o),
    .busy_o      (tx_busy_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      popped_valid_q <= pop_ok;
      accepted_q     <= accepted;
      count_q        <= count_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign popped_valid_o  = popped_valid_q;
  assign popped_byte_o   = popped_valid_q ? rd_data : 8'd0;
  assign fifo_count_o    = count_q;
  assign send_accepted_o = accepted_q;

endmodule

`default_nettype wire
